### design/vertex_dedup_indexer_top_macros.svh
// ----------------------------------------------------------------------------
// Vertex dedup indexer assertion macros
// Concurrent assertion wrappers used by the top design file; define ASSERT_OFF
// to compile them out.
// ----------------------------------------------------------------------------
`ifndef VERTEX_DEDUP_INDEXER_TOP_MACROS_SVH
`define VERTEX_DEDUP_INDEXER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define VDI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define VDI_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define VDI_ASSERT(lbl, clk, rst, prop, msg)
`define VDI_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

### design/vdi_pkg.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer package
// Shared types, constants and the saturating accumulate function.
// ----------------------------------------------------------------------------
package vdi_pkg;

   localparam int MAX_ENTRIES_DEF = 1024;
   localparam int NUM_COMPS       = 8;
   localparam int KEY_W           = 128;

   localparam logic       OP_SUBMIT     = 1'b0;
   localparam logic       OP_READ       = 1'b1;
   localparam logic [0:0] ADDR_TOL      = 1'b0;
   localparam logic [7:0] TOL_RESET     = 8'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_FETCH,
      ST_UPDATE,
      ST_APPEND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [47:0] bitangent_sum;
      logic [47:0] tangent_sum;
      logic [47:0] normal;
      logic [31:0] tex_coord;
      logic [47:0] position;
   } entry_type;

   typedef struct packed {
      logic vld;
      logic near;
      logic last;
   } cell_ctl_type;

   function automatic logic [47:0] sat_add3(input logic [47:0] a, input logic [47:0] b);
      logic [47:0]        r;
      logic signed [16:0] s;
      r = '0;
      for (int k = 0; k < 3; k++) begin
         s = $signed({a[16*k+15], a[16*k +: 16]}) + $signed({b[16*k+15], b[16*k +: 16]});
         if (s > 17'sd32767) begin
            r[16*k +: 16] = 16'h7FFF;
         end else if (s < -17'sd32768) begin
            r[16*k +: 16] = 16'h8000;
         end else begin
            r[16*k +: 16] = s[15:0];
         end
      end
      return r;
   endfunction

endpackage

### design/vdi_cell.sv
// ----------------------------------------------------------------------------
// Vertex dedup compare cell
// Compares one Q7.8 component of a stored entry against the item and passes
// the entry, with its running match flag, to the next cell.
// ----------------------------------------------------------------------------
module vdi_cell #(
   parameter int IDX_W   = 10,
   parameter int CMP_SEL = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       flush,
   input  logic [7:0]                 tolerance,
   input  logic [15:0]                item_comp,
   input  vdi_pkg::cell_ctl_type      in_ctl,
   input  logic [IDX_W-1:0]           in_idx,
   input  logic [vdi_pkg::KEY_W-1:0]  in_key,
   output vdi_pkg::cell_ctl_type      out_ctl,
   output logic [IDX_W-1:0]           out_idx,
   output logic [vdi_pkg::KEY_W-1:0]  out_key
);

   logic [15:0]           stored_comp;
   logic signed [16:0]    diff;
   logic [16:0]           mag;
   logic                  close;
   vdi_pkg::cell_ctl_type ctl_ff;
   vdi_pkg::cell_ctl_type ctl_in;
   logic [IDX_W-1:0]      idx_ff;
   logic [vdi_pkg::KEY_W-1:0] key_ff;

   assign stored_comp = in_key[16*CMP_SEL +: 16];
   assign diff  = $signed({item_comp[15], item_comp}) - $signed({stored_comp[15], stored_comp});
   assign mag   = diff[16] ? 17'(-diff) : 17'(diff);
   assign close = mag < {9'd0, tolerance};

   always_comb begin
      ctl_in      = in_ctl;
      ctl_in.near = in_ctl.near & close;
      ctl_in.vld  = in_ctl.vld & ~flush;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= in_idx;
      key_ff <= in_key;
   end

   assign out_ctl = ctl_ff;
   assign out_idx = idx_ff;
   assign out_key = key_ff;

endmodule

### design/vdi_mem.sv
// ----------------------------------------------------------------------------
// Vertex dedup entry memory
// One write port and one registered read port holding the unique entries.
// ----------------------------------------------------------------------------
module vdi_mem #(
   parameter int DEPTH = 1024,
   parameter int IDX_W = 10
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  vdi_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output vdi_pkg::entry_type  rd_data
);

   vdi_pkg::entry_type mem [DEPTH];
   vdi_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/vertex_dedup_indexer_top.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer
// Builds an indexed vertex table: each submitted vertex is matched against
// the stored unique entries in insertion order, or appended as a new one.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Beat content
//   req_*     in         req_valid/stall    opcode and one vertex or index
//   rsp_*     out        rsp_valid/stall    index, flags, read entry, count
//   APB       in/out     psel/penable       match_tolerance register
//
// A submit beat scans the stored entries until one matches or the last one
// is compared, and skips the scan on an empty table. Its length is set by
// the scan, which reads one stored entry per cycle from the single read
// port of the entry memory into a row of eight compare cells. Reset is
// synchronous, clears the entry count and loads the tolerance register
// with its reset value of 3; the memory itself is not cleared, since
// entries at or above the count are never used. The block takes one beat
// at a time; a finished response waits in the output register while the
// next request beat is accepted, and rsp_stall only holds the block back
// when a second response is ready before the first one has gone.
// ----------------------------------------------------------------------------
`include "vertex_dedup_indexer_top_macros.svh"

module vertex_dedup_indexer_top #(
   parameter int MAX_ENTRIES = vdi_pkg::MAX_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_opcode,
   input  logic [47:0]  req_position,
   input  logic [31:0]  req_tex_coord,
   input  logic [47:0]  req_normal_vec,
   input  logic [47:0]  req_tangent_vec,
   input  logic [47:0]  req_bitangent_vec,
   input  logic [9:0]   req_read_index,
   // Response channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [9:0]   rsp_vertex_index,
   output logic         rsp_found,
   output logic         rsp_table_full,
   output logic [47:0]  rsp_entry_position,
   output logic [31:0]  rsp_entry_tex_coord,
   output logic [47:0]  rsp_entry_normal,
   output logic [47:0]  rsp_entry_tangent_sum,
   output logic [47:0]  rsp_entry_bitangent_sum,
   output logic [10:0]  rsp_unique_count,
   // Configuration port
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [0:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int RD_W  = (CNT_W > 10) ? CNT_W : 10;
   localparam int NC    = vdi_pkg::NUM_COMPS;

   // Configuration register.
   logic [7:0] tol_ff;

   assign pready = 1'b1;
   assign prdata = (paddr == vdi_pkg::ADDR_TOL) ? {24'd0, tol_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= vdi_pkg::TOL_RESET;
      end else if (psel && penable && pwrite && pready && paddr == vdi_pkg::ADDR_TOL) begin
         tol_ff <= pwdata[7:0];
      end
   end

   // Control state.
   vdi_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff;
   logic [IDX_W-1:0]   scan_addr_ff;
   logic               issuing_ff;
   logic               issue_vld_ff;
   logic               issue_last_ff;
   logic [IDX_W-1:0]   issue_idx_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic               rsp_valid_ff;

   // Item and result payload.
   logic                       op_ff;
   logic [vdi_pkg::KEY_W-1:0]  key_ff;
   logic [47:0]                tan_ff;
   logic [47:0]                bitan_ff;
   logic [IDX_W-1:0]           rd_idx_ff;
   logic                       rd_ok_ff;
   logic [IDX_W-1:0]           res_idx_ff;
   logic                       res_found_ff;
   logic                       res_full_ff;

   logic [9:0]   rsp_vertex_index_ff;
   logic         rsp_found_ff;
   logic         rsp_table_full_ff;
   logic [47:0]  rsp_entry_position_ff;
   logic [31:0]  rsp_entry_tex_coord_ff;
   logic [47:0]  rsp_entry_normal_ff;
   logic [47:0]  rsp_entry_tangent_sum_ff;
   logic [47:0]  rsp_entry_bitangent_sum_ff;
   logic [10:0]  rsp_unique_count_ff;

   logic req_take;
   logic out_free;
   logic table_is_full;
   logic scan_end;
   logic hit_now;
   logic miss_now;

   // Memory ports.
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   vdi_pkg::entry_type mem_wr_data;
   logic               mem_rd_en;
   logic [IDX_W-1:0]   mem_rd_addr;
   vdi_pkg::entry_type mem_rd_data;

   // Compare chain.
   vdi_pkg::cell_ctl_type     chain_ctl [NC+1];
   logic [IDX_W-1:0]          chain_idx [NC+1];
   logic [vdi_pkg::KEY_W-1:0] chain_key [NC+1];

   assign req_take      = req_valid && !req_stall;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign table_is_full = count_ff == CNT_W'(MAX_ENTRIES);
   assign scan_end      = scan_addr_ff == IDX_W'(count_ff - CNT_W'(1));
   assign hit_now  = (state_ff == vdi_pkg::ST_SCAN) && chain_ctl[NC].vld && chain_ctl[NC].near;
   assign miss_now = (state_ff == vdi_pkg::ST_SCAN) && chain_ctl[NC].vld &&
                     !chain_ctl[NC].near && chain_ctl[NC].last;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vdi_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_opcode == vdi_pkg::OP_READ) begin
                  state_in = vdi_pkg::ST_READ;
               end else if (count_ff == '0) begin
                  state_in = vdi_pkg::ST_APPEND;
               end else begin
                  state_in = vdi_pkg::ST_SCAN;
               end
            end
         end
         vdi_pkg::ST_READ:   state_in = vdi_pkg::ST_DONE;
         vdi_pkg::ST_SCAN: begin
            priority if (hit_now) begin
               state_in = vdi_pkg::ST_FETCH;
            end else if (miss_now) begin
               state_in = vdi_pkg::ST_APPEND;
            end else begin
               state_in = vdi_pkg::ST_SCAN;
            end
         end
         vdi_pkg::ST_FETCH:  state_in = vdi_pkg::ST_UPDATE;
         vdi_pkg::ST_UPDATE: state_in = vdi_pkg::ST_DONE;
         vdi_pkg::ST_APPEND: state_in = vdi_pkg::ST_DONE;
         vdi_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = vdi_pkg::ST_IDLE;
            end
         end
         default: state_in = vdi_pkg::ST_IDLE;
      endcase
   end

   // State outputs: handshake and memory control.
   always_comb begin
      req_stall   = 1'b1;
      mem_rd_en   = 1'b0;
      mem_rd_addr = scan_addr_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = hit_idx_ff;
      mem_wr_data = mem_rd_data;
      unique case (state_ff)
         vdi_pkg::ST_IDLE: req_stall = 1'b0;
         vdi_pkg::ST_READ: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = rd_idx_ff;
         end
         vdi_pkg::ST_SCAN: begin
            mem_rd_en   = issuing_ff && !hit_now;
            mem_rd_addr = scan_addr_ff;
         end
         vdi_pkg::ST_FETCH: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = hit_idx_ff;
         end
         vdi_pkg::ST_UPDATE: begin
            mem_wr_en                 = 1'b1;
            mem_wr_addr               = hit_idx_ff;
            mem_wr_data               = mem_rd_data;
            mem_wr_data.tangent_sum   = vdi_pkg::sat_add3(mem_rd_data.tangent_sum, tan_ff);
            mem_wr_data.bitangent_sum = vdi_pkg::sat_add3(mem_rd_data.bitangent_sum, bitan_ff);
         end
         vdi_pkg::ST_APPEND: begin
            mem_wr_en                 = !table_is_full;
            mem_wr_addr               = IDX_W'(count_ff);
            mem_wr_data.position      = key_ff[47:0];
            mem_wr_data.tex_coord     = key_ff[79:48];
            mem_wr_data.normal        = key_ff[127:80];
            mem_wr_data.tangent_sum   = tan_ff;
            mem_wr_data.bitangent_sum = bitan_ff;
         end
         vdi_pkg::ST_DONE: req_stall = 1'b1;
         default:          req_stall = 1'b1;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= vdi_pkg::ST_IDLE;
         count_ff      <= '0;
         issuing_ff    <= 1'b0;
         issue_vld_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_vld_ff <= (state_ff == vdi_pkg::ST_SCAN) && issuing_ff && !hit_now;
         if (req_take) begin
            issuing_ff <= req_opcode == vdi_pkg::OP_SUBMIT;
         end else if (state_ff == vdi_pkg::ST_SCAN && (hit_now || scan_end)) begin
            issuing_ff <= 1'b0;
         end
         if (state_ff == vdi_pkg::ST_APPEND && !table_is_full) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (state_ff == vdi_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      issue_idx_ff  <= scan_addr_ff;
      issue_last_ff <= scan_end;
      if (req_take) begin
         op_ff        <= req_opcode;
         key_ff       <= {req_normal_vec, req_tex_coord, req_position};
         tan_ff       <= req_tangent_vec;
         bitan_ff     <= req_bitangent_vec;
         rd_idx_ff    <= IDX_W'(req_read_index);
         rd_ok_ff     <= RD_W'(req_read_index) < RD_W'(count_ff);
         scan_addr_ff <= '0;
         res_idx_ff   <= '0;
         res_found_ff <= 1'b0;
         res_full_ff  <= 1'b0;
      end else if (state_ff == vdi_pkg::ST_SCAN && issuing_ff && !scan_end) begin
         scan_addr_ff <= scan_addr_ff + IDX_W'(1);
      end
      if (hit_now) begin
         hit_idx_ff <= chain_idx[NC];
      end
      if (state_ff == vdi_pkg::ST_UPDATE) begin
         res_idx_ff   <= hit_idx_ff;
         res_found_ff <= 1'b1;
      end
      if (state_ff == vdi_pkg::ST_APPEND) begin
         res_idx_ff  <= table_is_full ? '0 : IDX_W'(count_ff);
         res_full_ff <= table_is_full;
      end
      if (state_ff == vdi_pkg::ST_DONE && out_free) begin
         rsp_vertex_index_ff <= 10'(res_idx_ff);
         rsp_found_ff        <= res_found_ff;
         rsp_table_full_ff   <= res_full_ff;
         rsp_unique_count_ff <= 11'(count_ff);
         if (op_ff == vdi_pkg::OP_READ && rd_ok_ff) begin
            rsp_entry_position_ff      <= mem_rd_data.position;
            rsp_entry_tex_coord_ff     <= mem_rd_data.tex_coord;
            rsp_entry_normal_ff        <= mem_rd_data.normal;
            rsp_entry_tangent_sum_ff   <= mem_rd_data.tangent_sum;
            rsp_entry_bitangent_sum_ff <= mem_rd_data.bitangent_sum;
         end else begin
            rsp_entry_position_ff      <= '0;
            rsp_entry_tex_coord_ff     <= '0;
            rsp_entry_normal_ff        <= '0;
            rsp_entry_tangent_sum_ff   <= '0;
            rsp_entry_bitangent_sum_ff <= '0;
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_vertex_index        = rsp_vertex_index_ff;
   assign rsp_found               = rsp_found_ff;
   assign rsp_table_full          = rsp_table_full_ff;
   assign rsp_entry_position      = rsp_entry_position_ff;
   assign rsp_entry_tex_coord     = rsp_entry_tex_coord_ff;
   assign rsp_entry_normal        = rsp_entry_normal_ff;
   assign rsp_entry_tangent_sum   = rsp_entry_tangent_sum_ff;
   assign rsp_entry_bitangent_sum = rsp_entry_bitangent_sum_ff;
   assign rsp_unique_count        = rsp_unique_count_ff;

   vdi_mem #(
      .DEPTH (MAX_ENTRIES),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // The entry read in the previous cycle enters the first cell. Each cell checks
   // one component; a match leaves the last cell with its near flag still
   // set, and the first such entry to leave wins. A hit flushes the entries
   // still in flight behind it.
   assign chain_ctl[0].vld  = issue_vld_ff;
   assign chain_ctl[0].near = 1'b1;
   assign chain_ctl[0].last = issue_last_ff;
   assign chain_idx[0]      = issue_idx_ff;
   assign chain_key[0]      = {mem_rd_data.normal, mem_rd_data.tex_coord, mem_rd_data.position};

   for (genvar g = 0; g < NC; g++) begin : g_cell
      vdi_cell #(
         .IDX_W   (IDX_W),
         .CMP_SEL (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .flush     (hit_now),
         .tolerance (tol_ff),
         .item_comp (key_ff[16*g +: 16]),
         .in_ctl    (chain_ctl[g]),
         .in_idx    (chain_idx[g]),
         .in_key    (chain_key[g]),
         .out_ctl   (chain_ctl[g+1]),
         .out_idx   (chain_idx[g+1]),
         .out_key   (chain_key[g+1])
      );
   end

   // The table never holds more than its depth.
   `VDI_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_ENTRIES), "count overflow")
   // The count only ever grows by one entry at a time.
   `VDI_ASSERT(a_count_step, clock, reset, (!$past(reset) && count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + CNT_W'(1)), "count jumped")
   // A compared entry always lies below the current count.
   `VDI_ASSERT(a_scan_idx, clock, reset, (state_ff == vdi_pkg::ST_SCAN && chain_ctl[NC].vld) |-> (CNT_W'(chain_idx[NC]) < count_ff), "scan beyond count")
   // A response never reports both a match and a full table.
   `VDI_ASSERT_NEVER(a_flags, clock, reset, rsp_valid_ff && rsp_found_ff && rsp_table_full_ff, "found with full")

endmodule
